// ===== rtl/sgm_pkg.sv =====
package sgm_pkg;

  // Field widths of the item and result ports
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 20;
  localparam int OFF_W  = 24;
  localparam int MODE_W = 3;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SEGMENTS = 16;
  localparam int DEF_LEN_BITS     = 20;

  // A map emits at most this many chunks
  localparam int RESULT_CAP = 16;
  localparam int CHUNK_CW   = $clog2(RESULT_CAP + 1);

  // Front-to-back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_MAP        = 3'd4
  } sgm_mode_e;

  // Operation after the static checks of the front end
  typedef enum logic [2:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_MAP,
    OP_REJECT
  } sgm_op_e;

  typedef struct packed {
    sgm_op_e           op;
    logic [ADDR_W-1:0] seg_base;
    logic [LEN_W-1:0]  seg_len;
    logic [OFF_W-1:0]  start_offset;
    logic [OFF_W-1:0]  range_len;
  } sgm_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEEK,
    ST_EMIT
  } sgm_state_e;

endpackage

// ===== rtl/sgm_front.sv =====
module sgm_front
  import sgm_pkg::*;
#(
  parameter int LEN_BITS = DEF_LEN_BITS
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [ADDR_W-1:0] seg_base_i,
  input  logic [LEN_W-1:0]  seg_len_i,
  input  logic [OFF_W-1:0]  start_offset_i,
  input  logic [OFF_W-1:0]  range_len_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output sgm_item_t         q_item_o
);

  localparam int SLEN = (LEN_BITS < LEN_W) ? LEN_BITS : LEN_W;
  localparam logic [LEN_W-1:0] LEN_MASK = LEN_W'((64'd1 << SLEN) - 64'd1);

  logic [LEN_W-1:0] len_m;

  assign len_m      = seg_len_i & LEN_MASK;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.seg_base     = seg_base_i;
    q_item_o.seg_len      = len_m;
    q_item_o.start_offset = start_offset_i;
    q_item_o.range_len    = range_len_i;
    unique case (mode_i) inside
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (seg_base_i == '0 || len_m == '0) begin
          q_item_o.op = OP_REJECT;
        end else if (mode_i == MODE_PUSH_FRONT) begin
          q_item_o.op = OP_PUSH_FRONT;
        end else begin
          q_item_o.op = OP_PUSH_BACK;
        end
      end
      MODE_POP_BACK:  q_item_o.op = OP_POP_BACK;
      MODE_POP_FRONT: q_item_o.op = OP_POP_FRONT;
      MODE_MAP: begin
        q_item_o.op = (range_len_i == '0) ? OP_REJECT : OP_MAP;
      end
      default: q_item_o.op = OP_REJECT;
    endcase
  end

endmodule

// ===== rtl/sgm_queue.sv =====
module sgm_queue
  import sgm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sgm_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output sgm_item_t item_o
);

  sgm_item_t        slot_q [Q_DEPTH];
  logic [Q_PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [Q_PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == Q_CW'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/sgm_back.sv =====
module sgm_back
  import sgm_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int LEN_BITS     = DEF_LEN_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  sgm_item_t         q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              status_o,
  output logic [ADDR_W-1:0] chunk_base_o,
  output logic [LEN_W-1:0]  chunk_len_o,
  output logic              last_o,
  output logic [OFF_W-1:0]  bytes_covered_o
);

  localparam int SLEN = (LEN_BITS < LEN_W) ? LEN_BITS : LEN_W;
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int TW   = SLEN + CW;
  localparam int AW   = (TW > OFF_W) ? TW : OFF_W;

  // segment table
  logic [ADDR_W-1:0] base_mem [MAX_SEGMENTS];
  logic [SLEN-1:0]   len_mem  [MAX_SEGMENTS];
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [ADDR_W-1:0] rd_base_q;
  logic [SLEN-1:0]   rd_len_q;

  sgm_state_e        state_q, state_d;
  logic [IW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [TW-1:0]     total_q, total_d;

  // map walk
  logic [CW-1:0]       idx_q, idx_d;
  logic [TW-1:0]       pos_q, pos_d;
  logic [OFF_W-1:0]    left_q, left_d;
  logic [SLEN-1:0]     within_q, within_d;
  logic [CHUNK_CW-1:0] nchunk_q, nchunk_d;
  logic [OFF_W-1:0]    off_q, off_d;
  logic [OFF_W-1:0]    want_q, want_d;

  // result register
  logic              out_valid_q;
  logic              out_free;
  logic              out_load;
  logic              status_q, status_d;
  logic [ADDR_W-1:0] cbase_q, cbase_d;
  logic [LEN_W-1:0]  clen_q, clen_d;
  logic              last_q, last_d;
  logic [OFF_W-1:0]  covered_q, covered_d;

  logic [SLEN-1:0]     in_len;
  logic [CW-1:0]       idx_inc;
  logic [TW-1:0]       seg_end;
  logic                off_found;
  logic [SLEN-1:0]     room;
  logic [OFF_W:0]      need_sum;
  logic                fits;
  logic [SLEN-1:0]     take;
  logic [OFF_W-1:0]    left_nxt;
  logic [CHUNK_CW-1:0] nchunk_inc;
  logic                map_last;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(pos);
    if (sum >= (CW+1)'(MAX_SEGMENTS)) begin
      sum = sum - (CW+1)'(MAX_SEGMENTS);
    end
    return sum[IW-1:0];
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_len      = q_item_i.seg_len[SLEN-1:0];
  assign idx_inc     = idx_q + 1'b1;
  assign nchunk_inc  = nchunk_q + 1'b1;

  // seek: does the offset fall inside the segment at idx_q
  assign seg_end     = pos_q + TW'(rd_len_q);
  assign off_found   = AW'(off_q) < AW'(seg_end);

  // emit: left < room  <=>  left + within < len
  assign room        = rd_len_q - within_q;
  assign need_sum    = (OFF_W+1)'(left_q) + (OFF_W+1)'(within_q);
  assign fits        = need_sum < (OFF_W+1)'(rd_len_q);
  assign take        = fits ? left_q[SLEN-1:0] : room;
  assign left_nxt    = fits ? '0 : OFF_W'(need_sum - (OFF_W+1)'(rd_len_q));
  assign map_last    = (idx_inc == count_q) || (left_nxt == '0) ||
                       (nchunk_inc == CHUNK_CW'(RESULT_CAP));

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    total_d   = total_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    left_d    = left_q;
    within_d  = within_q;
    nchunk_d  = nchunk_q;
    off_d     = off_q;
    want_d    = want_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    rd_en     = 1'b0;
    rd_addr   = head_q;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    status_d  = 1'b1;
    cbase_d   = '0;
    clen_d    = '0;
    last_d    = 1'b1;
    covered_d = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_item_i.op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              out_load = 1'b1;
              if (count_q != CW'(MAX_SEGMENTS)) begin
                status_d = 1'b0;
                mem_we   = 1'b1;
                if (q_item_i.op == OP_PUSH_FRONT) begin
                  head_d    = (head_q == '0) ? IW'(MAX_SEGMENTS - 1) : head_q - 1'b1;
                  mem_waddr = head_d;
                end else begin
                  mem_waddr = slot_of(head_q, count_q);
                end
                count_d = count_q + 1'b1;
                total_d = total_q + TW'(in_len);
              end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
              if (count_q == '0) begin
                out_load = 1'b1;
              end else begin
                rd_en   = 1'b1;
                count_d = count_q - 1'b1;
                if (q_item_i.op == OP_POP_FRONT) begin
                  rd_addr = head_q;
                  head_d  = (head_q == IW'(MAX_SEGMENTS - 1)) ? '0 : head_q + 1'b1;
                end else begin
                  rd_addr = slot_of(head_q, count_q - 1'b1);
                end
                state_d = ST_POP;
              end
            end
            OP_MAP: begin
              if (AW'(q_item_i.start_offset) >= AW'(total_q)) begin
                out_load = 1'b1;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = head_q;
                idx_d    = '0;
                pos_d    = '0;
                nchunk_d = '0;
                left_d   = q_item_i.range_len;
                off_d    = q_item_i.start_offset;
                want_d   = q_item_i.range_len;
                state_d  = ST_SEEK;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end

      ST_POP: begin
        if (out_free) begin
          out_load = 1'b1;
          status_d = 1'b0;
          cbase_d  = rd_base_q;
          clen_d   = LEN_W'(rd_len_q);
          total_d  = total_q - TW'(rd_len_q);
          state_d  = ST_IDLE;
        end
      end

      // the offset lies below the total, so the walk always finds it
      ST_SEEK: begin
        if (off_found) begin
          within_d = SLEN'(AW'(off_q) - AW'(pos_q));
          state_d  = ST_EMIT;
        end else begin
          pos_d   = seg_end;
          idx_d   = idx_inc;
          rd_en   = 1'b1;
          rd_addr = slot_of(head_q, idx_inc);
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          status_d = 1'b0;
          cbase_d  = rd_base_q + ADDR_W'(within_q);
          clen_d   = LEN_W'(take);
          last_d   = map_last;
          if (map_last) begin
            covered_d = want_q - left_nxt;
            state_d   = ST_IDLE;
          end else begin
            idx_d    = idx_inc;
            nchunk_d = nchunk_inc;
            left_d   = left_nxt;
            within_d = '0;
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_q, idx_inc);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    left_q   <= left_d;
    within_q <= within_d;
    nchunk_q <= nchunk_d;
    off_q    <= off_d;
    want_q   <= want_d;
    if (out_load) begin
      status_q  <= status_d;
      cbase_q   <= cbase_d;
      clen_q    <= clen_d;
      last_q    <= last_d;
      covered_q <= covered_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      base_mem[mem_waddr] <= q_item_i.seg_base;
      len_mem[mem_waddr]  <= in_len;
    end
    if (rd_en) begin
      rd_base_q <= base_mem[rd_addr];
      rd_len_q  <= len_mem[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign chunk_base_o    = cbase_q;
  assign chunk_len_o     = clen_q;
  assign last_o          = last_q;
  assign bytes_covered_o = covered_q;

endmodule

// ===== rtl/scatter_gather_segment_mapper_core.sv =====
// Scatter-gather segment mapper. Holds a double-ended list of up to MAX_SEGMENTS
// (base, length) segments plus their byte total; items push or pop at either
// end, or map a logical (offset, length) range onto chunk descriptors, one per
// segment touched and at most RESULT_CAP, the final one flagged with last and
// the bytes covered. An item first lands in a two-entry queue, so up to two more
// items are taken while one is being processed. The segment table has a single
// read port: a push or a rejected item loads its result straight from idle, a
// pop reads its segment and then emits it, and a map reads segments one at a
// time, past those before the offset, emitting a chunk per segment. Output
// stalls hold emits and new items; results are registered, nothing is dropped.
module scatter_gather_segment_mapper_core
  import sgm_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int LEN_BITS     = DEF_LEN_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [ADDR_W-1:0] seg_base_i,
  input  logic [LEN_W-1:0]  seg_len_i,
  input  logic [OFF_W-1:0]  start_offset_i,
  input  logic [OFF_W-1:0]  range_len_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              status_o,
  output logic [ADDR_W-1:0] chunk_base_o,
  output logic [LEN_W-1:0]  chunk_len_o,
  output logic              last_o,
  output logic [OFF_W-1:0]  bytes_covered_o
);

  sgm_item_t push_item;
  sgm_item_t head_item;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;

  sgm_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .seg_base_i     (seg_base_i),
    .seg_len_i      (seg_len_i),
    .start_offset_i (start_offset_i),
    .range_len_i    (range_len_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (push_item)
  );

  sgm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  sgm_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .LEN_BITS     (LEN_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (head_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .chunk_base_o    (chunk_base_o),
    .chunk_len_o     (chunk_len_o),
    .last_o          (last_o),
    .bytes_covered_o (bytes_covered_o)
  );

endmodule

// ===== dv/tb_scatter_gather_segment_mapper_core.sv =====
module tb_scatter_gather_segment_mapper_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::*;

  localparam int SEGS        = DEF_MAX_SEGMENTS;
  localparam int SLOT_W      = $clog2(SEGS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int TOT_W       = OFF_W + 1;
  localparam int RAND_ITEMS  = 258;
  localparam int CALM_ITEMS  = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 64;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  want;
  } seg_cmd_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic [OFF_W-1:0]  covered;
  } chunk_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [ADDR_W-1:0] seg_base = '0;
  logic [LEN_W-1:0]  seg_len = '0;
  logic [OFF_W-1:0]  start_offset = '0;
  logic [OFF_W-1:0]  range_len = '0;
  logic              out_valid;
  logic              out_stall;
  logic              out_stall_q = 1'b0;
  logic              status;
  logic [ADDR_W-1:0] chunk_base;
  logic [LEN_W-1:0]  chunk_len;
  logic              last;
  logic [OFF_W-1:0]  bytes_covered;

  // shadow of the segment list
  logic [ADDR_W-1:0] sl_base [SEGS];
  logic [LEN_W-1:0]  sl_len  [SEGS];
  logic [SLOT_W-1:0] sl_head = '0;
  logic [CNT_W-1:0]  sl_count = '0;
  logic [TOT_W-1:0]  sl_total = '0;

  seg_cmd_t cmd_pending_q[$];
  chunk_t   chunk_expect_q[$];
  seg_cmd_t drv_cmd;

  int   in_gap = 0;
  int   out_gap = 0;
  int   hold_cnt = 0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;
  logic idle_on = 1'b1;
  logic calm = 1'b0;
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;

  scatter_gather_segment_mapper_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .seg_base_i     (seg_base),
    .seg_len_i      (seg_len),
    .start_offset_i (start_offset),
    .range_len_i    (range_len),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .chunk_base_o   (chunk_base),
    .chunk_len_o    (chunk_len),
    .last_o         (last),
    .bytes_covered_o(bytes_covered)
  );

  assign out_stall = out_stall_q | (hold_cnt != 0);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Updates the shadow list for one accepted item and queues the chunks it yields.
  function automatic void apply_segment_op(input seg_cmd_t c);
    chunk_t            r;
    logic [SLOT_W-1:0] s;
    logic [CNT_W-1:0]  idx;
    logic [TOT_W-1:0]  pos;
    logic [TOT_W-1:0]  left;
    logic [LEN_W-1:0]  seg_ofs;
    logic [LEN_W-1:0]  room;
    logic [LEN_W-1:0]  take;
    int                k;
    r = '0;
    r.status = 1'b1;
    r.last = 1'b1;
    case (c.mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (c.base != '0 && c.len != '0 && sl_count < CNT_W'(SEGS)) begin
          if (c.mode == MODE_PUSH_FRONT) begin
            sl_head = sl_head - 1'b1;
            s = sl_head;
          end else begin
            s = sl_head + SLOT_W'(sl_count);
          end
          sl_base[s] = c.base;
          sl_len[s] = c.len;
          sl_count = sl_count + 1'b1;
          sl_total = sl_total + TOT_W'(c.len);
          r.status = 1'b0;
        end
      end
      MODE_POP_BACK, MODE_POP_FRONT: begin
        if (sl_count != '0) begin
          if (c.mode == MODE_POP_FRONT) begin
            s = sl_head;
            sl_head = sl_head + 1'b1;
          end else begin
            s = sl_head + SLOT_W'(sl_count - 1'b1);
          end
          sl_count = sl_count - 1'b1;
          sl_total = sl_total - TOT_W'(sl_len[s]);
          r.status = 1'b0;
          r.addr = sl_base[s];
          r.len = sl_len[s];
        end
      end
      MODE_MAP: begin
        if (c.want != '0 && TOT_W'(c.off) < sl_total) begin
          // skip whole segments ahead of the offset
          pos = '0;
          idx = '0;
          while (TOT_W'(c.off) >= pos + TOT_W'(sl_len[sl_head + SLOT_W'(idx)])) begin
            pos = pos + TOT_W'(sl_len[sl_head + SLOT_W'(idx)]);
            idx = idx + 1'b1;
          end
          seg_ofs = LEN_W'(TOT_W'(c.off) - pos);
          left = TOT_W'(c.want);
          k = 0;
          while (idx < sl_count && left != '0 && k < RESULT_CAP) begin
            if (k != 0) chunk_expect_q = {chunk_expect_q, r};
            s = sl_head + SLOT_W'(idx);
            room = sl_len[s] - seg_ofs;
            take = (left < TOT_W'(room)) ? LEN_W'(left) : room;
            r = '0;
            r.addr = sl_base[s] + ADDR_W'(seg_ofs);
            r.len = take;
            left = left - TOT_W'(take);
            seg_ofs = '0;
            idx = idx + 1'b1;
            k++;
          end
          r.last = 1'b1;
          r.covered = OFF_W'(TOT_W'(c.want) - left);
        end
      end
      default: ;
    endcase
    chunk_expect_q = {chunk_expect_q, r};
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%t %s", $realtime, msg);
  endfunction

  task automatic queue_cmd(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] b,
                           input logic [LEN_W-1:0] l, input logic [OFF_W-1:0] o,
                           input logic [OFF_W-1:0] w);
    seg_cmd_t c;
    while (cmd_pending_q.size() >= 2) @(negedge clk_i);
    c = '{m, b, l, o, w};
    cmd_pending_q = {cmd_pending_q, c};
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_segment_op('{mode, seg_base, seg_len, start_offset, range_len});
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (cmd_pending_q.size() != 0) begin
          drv_cmd = cmd_pending_q[0];
          cmd_pending_q.delete(0);
          in_valid <= 1'b1;
          mode <= drv_cmd.mode;
          seg_base <= drv_cmd.base;
          seg_len <= drv_cmd.len;
          start_offset <= drv_cmd.off;
          range_len <= drv_cmd.want;
          if (idle_on && !calm && $urandom_range(0, 4) == 0) in_gap <= $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    chunk_t got;
    chunk_t exp_c;
    if (!rst_ni) begin
      out_stall_q <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status, chunk_base, chunk_len, last, bytes_covered};
        if (chunk_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected chunk: status=%0d base=%h len=%h last=%0d cov=%h",
                                  got.status, got.addr, got.len, got.last, got.covered));
        end else begin
          exp_c = chunk_expect_q[0];
          chunk_expect_q.delete(0);
          if (got !== exp_c) begin
            note_mismatch($sformatf({"chunk mismatch: exp status=%0d base=%h len=%h last=%0d ",
                                     "cov=%h, got status=%0d base=%h len=%h last=%0d cov=%h"},
                                    exp_c.status, exp_c.addr, exp_c.len, exp_c.last,
                                    exp_c.covered, got.status, got.addr, got.len, got.last,
                                    got.covered));
          end
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_stall_q <= 1'b1;
      end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 16);
        out_stall_q <= 1'b1;
      end else begin
        out_stall_q <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the input side backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_cnt <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic              grow;
    int                pick;
    int                sel;
    logic [ADDR_W-1:0] b;
    logic [LEN_W-1:0]  l;
    logic [OFF_W-1:0]  o;
    logic [OFF_W-1:0]  w;
    logic [TOT_W-1:0]  tot_view;
    grow = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: pops and map fail
    queue_cmd(MODE_POP_BACK, $urandom, LEN_W'($urandom), OFF_W'($urandom), OFF_W'($urandom));
    queue_cmd(MODE_POP_FRONT, $urandom, LEN_W'($urandom), OFF_W'($urandom), OFF_W'($urandom));
    queue_cmd(MODE_MAP, $urandom, LEN_W'($urandom), '0, 24'd1);
    // rejected pushes: zero base, zero length
    queue_cmd(MODE_PUSH_BACK, '0, 20'd5, '0, '0);
    queue_cmd(MODE_PUSH_BACK, 32'h0000_1000, '0, '0, '0);
    // list becomes (1,1) (ffffffff,fffff) (80000000,10), total 0x100010
    queue_cmd(MODE_PUSH_BACK, '1, '1, '1, '1);
    queue_cmd(MODE_PUSH_FRONT, 32'h1, 20'h1, '0, '0);
    queue_cmd(MODE_PUSH_BACK, 32'h8000_0000, 20'h10, '0, '0);
    // request beyond the end: covers the whole list
    queue_cmd(MODE_MAP, '0, '0, '0, '1);
    // chunk address wraps past the top of the address space
    queue_cmd(MODE_MAP, '0, '0, 24'd2, 24'd3);
    queue_cmd(MODE_MAP, '0, '0, 24'd4, '0);
    queue_cmd(MODE_MAP, '0, '0, 24'h10_0010, 24'd1);
    queue_cmd(MODE_MAP, '0, '0, '1, '1);
    queue_cmd(MODE_MAP, '0, '0, 24'h10_000f, 24'd1);
    for (int m = MODE_BAD_LO; m <= MODE_BAD_HI; m++) begin
      queue_cmd(MODE_W'(m), $urandom, LEN_W'($urandom), OFF_W'($urandom), OFF_W'($urandom));
    end
    queue_cmd(MODE_POP_FRONT, '0, '0, '0, '0);
    queue_cmd(MODE_POP_BACK, '0, '0, '0, '0);
    queue_cmd(MODE_POP_BACK, '0, '0, '0, '0);
    queue_cmd(MODE_PUSH_FRONT, 32'hdead_0000, 20'd3, '0, '0);
    queue_cmd(MODE_POP_FRONT, '0, '0, '0, '0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 30 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (i == 100) hold_go = 1'b1;
      if (i == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      // fill the table up, then drain it, so full and empty both recur
      if (grow && sl_count >= CNT_W'(SEGS)) grow = 1'b0;
      else if (!grow && sl_count == '0) grow = 1'b1;
      tot_view = sl_total;
      b = $urandom;
      l = LEN_W'($urandom);
      o = OFF_W'($urandom);
      w = OFF_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        sel = $urandom_range(0, 2);
        if (sel == 0) queue_cmd(MODE_W'($urandom_range(MODE_BAD_LO, MODE_BAD_HI)), b, l, o, w);
        else if (sel == 1) queue_cmd(MODE_PUSH_BACK, '0, l, o, w);
        else queue_cmd(MODE_PUSH_FRONT, b, '0, o, w);
      end else if (pick < 40) begin
        sel = $urandom_range(0, 9);
        if (sel <= 6) o = (tot_view != '0) ? OFF_W'($urandom_range(0, tot_view - 1)) : '0;
        else if (sel == 7) o = OFF_W'(tot_view);
        else if (sel == 9) o = '0;
        sel = $urandom_range(0, 9);
        if (sel <= 4) w = OFF_W'($urandom_range(1, 256));
        else if (sel <= 6) w = OFF_W'($urandom_range(1, 8192));
        else if (sel == 8) w = '1;
        else if (sel == 9 && $urandom_range(0, 3) == 0) w = '0;
        queue_cmd(MODE_MAP, b, l, o, w);
      end else if ($urandom_range(0, 99) < (grow ? 80 : 20)) begin
        sel = $urandom_range(0, 9);
        if (sel <= 5) l = LEN_W'($urandom_range(1, 64));
        else if (sel <= 7) l = LEN_W'($urandom_range(1, 4096));
        else if (sel == 9) l = '1;
        queue_cmd($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, b, l, o, w);
      end else begin
        queue_cmd($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK, b, l, o, w);
      end
    end

    while (cmd_pending_q.size() != 0 || in_valid) @(negedge clk_i);
    while (chunk_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (chunk_expect_q.size() != 0) begin
      note_mismatch($sformatf("%0d expected chunks never arrived", chunk_expect_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
